>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("label failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("label failed");

`endif

>>> hw/rtl/gsr_pkg.sv
// ----------------------------------------------------------------------------
// gsr_pkg
// Types, register indexes and fp32 / 16-bit float helpers for the reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package gsr_pkg;

    localparam int MaxGroupSize = 128;
    localparam int CntW         = $clog2(MaxGroupSize + 1);

    typedef enum logic [1:0] {
        REG_GROUP_SIZE    = 2'd0,
        REG_NUMBER_FORMAT = 2'd1,
        REG_REDUCE_BOTH   = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic bf16;
        logic both;
    } ctrl_t;

    localparam logic [31:0] Fp32QNan = 32'h7FC0_0000;

    // Exact widening to fp32.
    function automatic logic [31:0] widen(input logic [15:0] v, input logic bf16);
        logic [9:0] man;
        logic [7:0] e;
        logic       found;
        logic [3:0] lz;
        widen = 32'd0;
        man   = v[9:0];
        found = 1'b0;
        lz    = 4'd0;
        if (bf16) begin
            widen = {v, 16'd0};
        end else if (v[14:10] == 5'h1F) begin
            widen = {v[15], 8'hFF, man, 13'd0};
        end else if (v[14:10] != 5'd0) begin
            widen = {v[15], 3'b000, v[14:10] + 5'd0, man, 13'd0};
            widen[30:23] = {3'b000, v[14:10]} + 8'd112;
        end else if (man == 10'd0) begin
            widen = {v[15], 31'd0};
        end else begin
            for (int i = 9; i >= 0; i--) begin
                if (!found && man[i]) begin
                    found = 1'b1;
                    lz    = 4'(9 - i);
                end
            end
            man   = man << (lz + 4'd1);
            e     = 8'd113 - 8'(lz) - 8'd1;
            widen = {v[15], e, man, 13'd0};
        end
    endfunction

    // fp32 to fp16, round to nearest even.
    function automatic logic [15:0] narrow_fp16(input logic [31:0] x);
        logic        sign;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [23:0] m;
        logic [4:0]  sh;
        logic [23:0] r;
        logic [23:0] rem;
        logic [23:0] half;
        logic [10:0] rn;
        sign = x[31];
        ex   = x[30:23];
        man  = x[22:0];
        m    = {1'b1, man};
        sh   = 5'd0;
        r    = 24'd0;
        rem  = 24'd0;
        half = 24'd0;
        rn   = 11'd0;
        if (ex == 8'hFF) begin
            narrow_fp16 = (man != 23'd0) ? 16'h7E00 : {sign, 15'h7C00};
        end else if (ex == 8'd0) begin
            narrow_fp16 = {sign, 15'd0};
        end else if (ex >= 8'd143) begin
            narrow_fp16 = {sign, 15'h7C00};
        end else if (ex <= 8'd112) begin
            if (ex < 8'd102) begin
                narrow_fp16 = {sign, 15'd0};
            end else begin
                sh   = 5'(8'd126 - ex);
                r    = m >> sh;
                half = 24'd1 << (sh - 5'd1);
                rem  = m & ((24'd1 << sh) - 24'd1);
                if (rem > half || (rem == half && r[0]))
                    r = r + 24'd1;
                narrow_fp16 = {sign, r[14:0]};
            end
        end else begin
            r  = {9'd0, 5'(ex - 8'd112), man[22:13]};
            if (man[12:0] > 13'h1000 || (man[12:0] == 13'h1000 && r[0]))
                r = r + 24'd1;
            narrow_fp16 = {sign, r[14:0]};
        end
    endfunction

    // fp32 to bf16, round to nearest even.
    function automatic logic [15:0] narrow_bf16(input logic [31:0] x);
        logic [32:0] s;
        s = 33'(x) + 33'h7FFF + 33'(x[16]);
        if (x[30:23] == 8'hFF && x[22:0] != 23'd0)
            narrow_bf16 = 16'h7FC0;
        else
            narrow_bf16 = s[31:16];
    endfunction

    function automatic logic [15:0] narrow(input logic [31:0] x, input logic bf16);
        narrow = bf16 ? narrow_bf16(x) : narrow_fp16(x);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gsr_lane.sv
// ----------------------------------------------------------------------------
// gsr_lane
// One fp32 accumulator lane: widen, add with round to nearest even, hold.
// ----------------------------------------------------------------------------
`default_nettype none

module gsr_lane (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        take,
    input  wire logic        enable,
    input  wire logic        done,
    input  wire logic        bf16,
    input  wire logic [15:0] elem,
    output logic      [31:0] sum,
    output logic      [31:0] acc
);
    import gsr_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic [31:0] a, b, v;
    logic        sa, sb, hid_a, hid_b;
    logic [8:0]  ea, eb, e;
    logic [8:0]  d;
    logic [26:0] xa, xb, xs;
    logic        sticky;
    logic [27:0] s;
    logic [4:0]  lz;
    logic        found;
    logic [4:0]  shl;
    logic [24:0] mr;
    logic        rup;

    assign v = widen(elem, bf16);

    always_comb begin
        // order the operands by magnitude
        if (acc_reg[30:0] >= v[30:0]) begin
            a = acc_reg;
            b = v;
        end else begin
            a = v;
            b = acc_reg;
        end
        sa     = a[31];
        sb     = b[31];
        hid_a  = a[30:23] != 8'd0;
        hid_b  = b[30:23] != 8'd0;
        ea     = hid_a ? {1'b0, a[30:23]} : 9'd1;
        eb     = hid_b ? {1'b0, b[30:23]} : 9'd1;
        d      = ea - eb;
        xa     = {hid_a, a[22:0], 3'b000};
        xb     = {hid_b, b[22:0], 3'b000};
        if (d >= 9'd27) begin
            xs     = 27'd0;
            sticky = xb != 27'd0;
        end else begin
            xs     = xb >> d;
            sticky = (xb & ((27'd1 << d) - 27'd1)) != 27'd0;
        end
        xs[0] = xs[0] | sticky;
        if (sa == sb)
            s = {1'b0, xa} + {1'b0, xs};
        else
            s = {1'b0, xa} - {1'b0, xs};

        e     = ea;
        lz    = 5'd0;
        found = 1'b0;
        shl   = 5'd0;
        if (s[27]) begin
            s = {1'b0, s[27:2], s[1] | s[0]};
            e = e + 9'd1;
        end else begin
            for (int i = 26; i >= 0; i--) begin
                if (!found && s[i]) begin
                    found = 1'b1;
                    lz    = 5'(26 - i);
                end
            end
            shl = (9'(lz) > e - 9'd1) ? 5'(e - 9'd1) : lz;
            s   = s << shl;
            e   = e - 9'(shl);
        end
        rup = s[2] & (s[1] | s[0] | s[3]);
        mr  = {1'b0, s[26:3]} + 25'(rup);
        if (mr[24]) begin
            mr = mr >> 1;
            e  = e + 9'd1;
        end

        if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
            if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) ||
                (b[30:23] == 8'hFF && b[22:0] != 23'd0) ||
                (b[30:23] == 8'hFF && sa != sb))
                sum = Fp32QNan;
            else
                sum = {sa, 8'hFF, 23'd0};
        end else if (s == 28'd0) begin
            sum = {sa & sb, 31'd0};
        end else if (e >= 9'd255) begin
            sum = {sa, 8'hFF, 23'd0};
        end else begin
            sum = {sa, mr[23] ? e[7:0] : 8'd0, mr[22:0]};
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (take) begin
            if (done)
                acc_next = 32'd0;
            else if (enable)
                acc_next = sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            acc_reg <= 32'd0;
        else
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gsr_merge.sv
// ----------------------------------------------------------------------------
// gsr_merge
// Holds finished lane sums, narrows them to 16 bits and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gsr_merge (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire gsr_pkg::ctrl_t       ctrl,
    input  wire logic          [31:0] first_fp32,
    input  wire logic          [31:0] second_fp32,
    output logic                      push_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic               [31:0] m_tdata
);
    import gsr_pkg::*;

    logic           st_valid_reg, st_valid_next;
    logic [31:0]    st_a_reg, st_b_reg;
    ctrl_t          st_ctrl_reg;
    logic           out_valid_reg, out_valid_next;
    logic [31:0]    out_data_reg;
    logic           out_free, st_adv;
    logic [15:0]    first_sum, second_sum;

    assign out_free   = !out_valid_reg || m_tready;
    assign st_adv     = st_valid_reg && out_free;
    assign push_ready = !st_valid_reg || st_adv;

    assign first_sum  = narrow(st_a_reg, st_ctrl_reg.bf16);
    assign second_sum = st_ctrl_reg.both ? narrow(st_b_reg, st_ctrl_reg.bf16) : 16'd0;

    always_comb begin
        st_valid_next = st_valid_reg;
        if (push)
            st_valid_next = 1'b1;
        else if (st_adv)
            st_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (st_adv)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            st_a_reg    <= first_fp32;
            st_b_reg    <= second_fp32;
            st_ctrl_reg <= ctrl;
        end
        if (st_adv)
            out_data_reg <= {second_sum, first_sum};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/grouped_half_float_sum_reducer.sv
// ----------------------------------------------------------------------------
// grouped_half_float_sum_reducer
// Two-lane fp32 group accumulator over fp16/bf16 elements.
// ----------------------------------------------------------------------------
//  channel  | dir | beat payload
//  s_axis   | in  | tdata: first_elem[15:0], second_elem[31:16]
//  m_axis   | out | tdata: first_sum[15:0], second_sum[31:16]
//  cfg      | in  | cfg_addr selects group_size / number_format / reduce_both
//
// One beat per cycle while s_tready is high: each lane does its fp32 add in
// the accept cycle. A finished group's sums pass a hold stage and then the
// narrowing output register before they appear on m_axis. Input stalls only
// while the hold stage and output register are full and m_tready is low.
// Reset is synchronous; it clears sums, count and config to defaults.
`default_nettype none

`include "assert_macros.svh"

module grouped_half_float_sum_reducer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // first_elem, second_elem
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // first_sum, second_sum
);
    import gsr_pkg::*;

    logic [7:0]      group_size_reg;
    logic            bf16_reg, both_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [CntW-1:0] size;
    logic            take, done, push_ready;
    logic [31:0]     first_fp32, second_fp32, first_acc, second_acc;
    ctrl_t           ctrl;
    logic            group_clear;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= 8'd1;
            bf16_reg       <= 1'b0;
            both_reg       <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_GROUP_SIZE:    group_size_reg <= cfg_wr_data;
                REG_NUMBER_FORMAT: bf16_reg       <= cfg_wr_data[0];
                REG_REDUCE_BOTH:   both_reg       <= cfg_wr_data[0];
                default:           ;
            endcase
        end
    end

    // clamp the group size into 1..MaxGroupSize
    always_comb begin
        if (group_size_reg == 8'd0)
            size = CntW'(1);
        else if (32'(group_size_reg) > MaxGroupSize)
            size = CntW'(MaxGroupSize);
        else
            size = CntW'(group_size_reg);
    end

    assign s_tready = push_ready;
    assign take     = s_tvalid && s_tready;
    assign done     = ({1'b0, cnt_reg} + 1'b1) >= {1'b0, size};
    assign cnt_next = take ? (done ? '0 : cnt_reg + 1'b1) : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign ctrl = '{bf16: bf16_reg, both: both_reg};

    gsr_lane u_lane0 (
        .aclk, .aresetn, .take, .done,
        .enable (1'b1),
        .bf16   (bf16_reg),
        .elem   (s_tdata[15:0]),
        .sum    (first_fp32),
        .acc    (first_acc)
    );

    gsr_lane u_lane1 (
        .aclk, .aresetn, .take, .done,
        .enable (both_reg),
        .bf16   (bf16_reg),
        .elem   (s_tdata[31:16]),
        .sum    (second_fp32),
        .acc    (second_acc)
    );

    gsr_merge u_merge (
        .aclk, .aresetn,
        .push        (take && done),
        .ctrl,
        .first_fp32,
        .second_fp32 (second_fp32),
        .push_ready,
        .m_tvalid, .m_tready, .m_tdata
    );

    assign group_clear = first_acc == 32'd0 && second_acc == 32'd0 && cnt_reg == '0;

    `ASSERT_NEXT(a_clear_after_group, aclk, aresetn, take && done, group_clear)
    `ASSERT_IMPL(a_count_below_size_max, aclk, aresetn, 1'b1, 32'(cnt_reg) < MaxGroupSize)

endmodule

`default_nettype wire
